>>> rtl/core/pmf_pkg.sv
// shared types, constants and codes for the page map first-fit allocator
`default_nettype none

package pmf_pkg;

  // sizing
  localparam int DEFAULT_MAX_PAGES = 1024;
  localparam int LANES     = 16;               // page states per map word
  localparam int LANE_W    = 4;                // lane index width
  localparam int PG_BITS   = 2;
  localparam int WORD_BITS = LANES * PG_BITS;
  localparam int IDX_W     = 10;               // page_index / first_page field width
  localparam int CNT_W     = 11;               // page_count field width
  localparam int HEAP_W    = 11;               // heap_pages register width
  localparam int PAGE_W    = 11;               // page numbers inside the heap, run lengths
  localparam int SUM_W     = 12;               // page_index + page_count
  localparam int WCNT_W    = 8;                // map word counter, one past the last word

  localparam logic [HEAP_W-1:0] HEAP_RESET = 11'd1024;

  typedef logic [WORD_BITS-1:0] map_word_t;

  // request codes
  typedef enum logic [1:0] {
    ACT_ALLOC      = 2'd0,
    ACT_DIRTY      = 2'd1,
    ACT_FREE       = 2'd2,
    ACT_FREE_DIRTY = 2'd3
  } action_t;

  // result codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  // per-page state codes
  typedef enum logic [1:0] {
    PG_FREE  = 2'd0,
    PG_ALLOC = 2'd1,
    PG_DIRTY = 2'd2
  } pg_state_t;

  // what the word unit does to one map word
  typedef enum logic [1:0] {
    WOP_SCAN  = 2'd0,
    WOP_FILL  = 2'd1,
    WOP_CLEAN = 2'd2
  } wop_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_SCAN  = 3'd2,
    S_FILL  = 3'd3,
    S_CLEAN = 3'd4,
    S_RESP  = 3'd5
  } fsm_state_t;

  // transaction payloads
  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] page_index;
    logic [CNT_W-1:0] page_count;
  } pmf_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] first_page;
  } pmf_out_t;

  // sequencer to word unit
  typedef struct packed {
    wop_t              mode;
    logic [PAGE_W-1:0] base;      // page number of lane 0
    logic [PAGE_W-1:0] heap;      // effective heap size
    logic [PAGE_W-1:0] count;     // requested run length
    logic [PAGE_W-1:0] run_in;    // free run ending just below lane 0
    logic [PAGE_W-1:0] lo;        // fill range, inclusive
    logic [PAGE_W-1:0] hi;        // fill range, exclusive
    pg_state_t         fill_val;
  } wop_ctrl_t;

  // word unit search result
  typedef struct packed {
    logic              hit;
    logic [PAGE_W-1:0] first;
    logic [PAGE_W-1:0] run_out;
  } scan_res_t;

endpackage

`default_nettype wire

>>> rtl/core/pmf_map_ram.sv
// page state map storage: one write port, one registered read port
`default_nettype none

module pmf_map_ram #(
  parameter int WORDS = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire pmf_pkg::map_word_t wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output pmf_pkg::map_word_t     rdata
);
  import pmf_pkg::*;

  map_word_t mem [0:WORDS-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pmf_word_ops.sv
// per-word lane logic: free run search, run fill and dirty cleanup
`default_nettype none

module pmf_word_ops (
  input  wire pmf_pkg::wop_ctrl_t ctrl_i,
  input  wire pmf_pkg::map_word_t rdata_i,
  output pmf_pkg::map_word_t      wdata_o,
  output pmf_pkg::scan_res_t      res_o
);
  import pmf_pkg::*;

  // free run search across the sixteen lanes
  always_comb begin
    logic              nf_seen;
    logic [LANE_W-1:0] last_nf;
    logic              hit;
    logic [LANE_W-1:0] hit_lane;
    logic [PAGE_W-1:0] page;
    logic              free_j;
    logic [PAGE_W-1:0] run_j;
    nf_seen  = 1'b0;
    last_nf  = '0;
    hit      = 1'b0;
    hit_lane = '0;
    for (int j = 0; j < LANES; j++) begin
      page   = ctrl_i.base + PAGE_W'(j);
      free_j = (page < ctrl_i.heap) && (rdata_i[PG_BITS*j +: PG_BITS] == PG_FREE);
      if (!free_j) begin
        nf_seen = 1'b1;
        last_nf = LANE_W'(j);
      end
      // length of the free run that ends at this lane
      run_j = !nf_seen ? ctrl_i.run_in + PAGE_W'(j + 1)
                       : PAGE_W'(j) - PAGE_W'(last_nf);
      if (free_j && !hit && (run_j >= ctrl_i.count)) begin
        hit      = 1'b1;
        hit_lane = LANE_W'(j);
      end
    end
    res_o.hit     = hit;
    res_o.first   = ctrl_i.base + PAGE_W'(hit_lane) + PAGE_W'(1) - ctrl_i.count;
    res_o.run_out = !nf_seen ? ctrl_i.run_in + PAGE_W'(LANES)
                             : PAGE_W'(LANES - 1) - PAGE_W'(last_nf);
  end

  // modified word for write-back
  always_comb begin
    logic [PAGE_W-1:0] page;
    logic [1:0]        st;
    wdata_o = rdata_i;
    for (int j = 0; j < LANES; j++) begin
      page = ctrl_i.base + PAGE_W'(j);
      st   = rdata_i[PG_BITS*j +: PG_BITS];
      case (ctrl_i.mode)
        WOP_FILL: begin
          if ((page >= ctrl_i.lo) && (page < ctrl_i.hi)) begin
            wdata_o[PG_BITS*j +: PG_BITS] = ctrl_i.fill_val;
          end
        end
        WOP_CLEAN: begin
          if ((page < ctrl_i.heap) && (st == PG_DIRTY)) begin
            wdata_o[PG_BITS*j +: PG_BITS] = PG_FREE;
          end
        end
        default: begin
          wdata_o[PG_BITS*j +: PG_BITS] = st;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/page_map_first_fit_allocator.sv
// top level: first-fit page allocator over a word-packed page state map
//
// One transaction at a time: start is taken while busy is low, and busy stays high until
// the result strobe (out_valid, one cycle, cannot be stalled) has been shown. The map
// sits in a single-port-write, registered-read memory, sixteen page states per word, and
// every operation that touches the map streams through it one word per cycle. With H the
// effective heap size and W = ceil(H/16): an allocate scans words from page 0 until the run
// is found (at most W words), then rewrites the words the run touches; mark dirty and free
// rewrite the words the run touches; free-dirty sweeps all W words; each then shows its
// result and returns to idle. Requests answered from their fields alone (zero-page
// allocate, oversize allocate, run past the heap, zero-page run, free-dirty on an empty
// heap) go straight to the result. After reset the map is cleared one word per cycle,
// ceil(MAX_PAGES/16) words (64 at the default size), with busy high; heap_pages writes are
// taken throughout.
`default_nettype none

module page_map_first_fit_allocator #(
  parameter int MAX_PAGES = pmf_pkg::DEFAULT_MAX_PAGES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire pmf_pkg::pmf_in_t             in_data,
  output logic                              out_valid,
  output pmf_pkg::pmf_out_t                 out_data,
  input  wire logic                         cfg_we,
  input  wire logic [pmf_pkg::HEAP_W-1:0]   cfg_wdata
);
  import pmf_pkg::*;

  localparam int WORDS = (MAX_PAGES + LANES - 1) / LANES;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  fsm_state_t        state_r, state_nxt;
  logic [HEAP_W-1:0] heap_pages_r;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [WCNT_W-1:0] iss_r, iss_nxt;
  logic [WCNT_W-1:0] dw_r, dw_nxt;
  logic [WCNT_W-1:0] last_r, last_nxt;
  logic              rv_r, rv_nxt;
  logic [PAGE_W-1:0] run_r, run_nxt;
  logic [PAGE_W-1:0] cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] lo_r, lo_nxt;
  logic [PAGE_W-1:0] hi_r, hi_nxt;
  pg_state_t         fill_val_r, fill_val_nxt;
  status_t           status_r, status_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;

  logic [PAGE_W-1:0] heap;
  logic [PAGE_W-1:0] heap_m1;
  logic [WCNT_W-1:0] heap_last;
  logic [SUM_W-1:0]  req_sum;
  logic [SUM_W-1:0]  req_sum_m1;
  logic              cnt_zero;
  logic              alloc_quick;
  logic              run_range;
  logic              run_quick;
  logic              issue;
  logic              at_last;
  logic [PAGE_W-1:0] found_hi;
  logic [PAGE_W-1:0] found_hm1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  map_word_t         ram_wdata;
  logic              ram_re;
  map_word_t         ram_rdata;
  map_word_t         upd_word;
  wop_ctrl_t         wctrl;
  scan_res_t         scan_res;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_pages_r <= HEAP_RESET;
    end else if (cfg_we) begin
      heap_pages_r <= cfg_wdata;
    end
  end

  // effective heap and request decode
  assign heap        = (int'(heap_pages_r) > MAX_PAGES) ? PAGE_W'(MAX_PAGES) : heap_pages_r;
  assign heap_m1     = heap - PAGE_W'(1);
  assign heap_last   = WCNT_W'(heap_m1[PAGE_W-1:LANE_W]);
  assign req_sum     = SUM_W'(in_data.page_index) + SUM_W'(in_data.page_count);
  assign req_sum_m1  = req_sum - SUM_W'(1);
  assign cnt_zero    = (in_data.page_count == '0);
  assign alloc_quick = cnt_zero || (in_data.page_count > heap);
  assign run_range   = (req_sum > SUM_W'(heap));
  assign run_quick   = run_range || cnt_zero;

  // sweep pipeline status
  assign issue     = (iss_r <= last_r);
  assign at_last   = rv_r && (dw_r == last_r);
  assign found_hi  = scan_res.first + cnt_r;
  assign found_hm1 = found_hi - PAGE_W'(1);

  // word unit control
  always_comb begin
    case (state_r)
      S_SCAN:  wctrl.mode = WOP_SCAN;
      S_FILL:  wctrl.mode = WOP_FILL;
      default: wctrl.mode = WOP_CLEAN;
    endcase
    wctrl.base     = {dw_r[WCNT_W-2:0], LANE_W'(0)};
    wctrl.heap     = heap;
    wctrl.count    = cnt_r;
    wctrl.run_in   = run_r;
    wctrl.lo       = lo_r;
    wctrl.hi       = hi_r;
    wctrl.fill_val = fill_val_r;
  end

  pmf_word_ops u_word_ops (
    .ctrl_i  (wctrl),
    .rdata_i (ram_rdata),
    .wdata_o (upd_word),
    .res_o   (scan_res)
  );

  pmf_map_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(iss_r)),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (in_data.action)
            ACT_ALLOC:          state_nxt = alloc_quick ? S_RESP : S_SCAN;
            ACT_DIRTY, ACT_FREE: state_nxt = run_quick ? S_RESP : S_FILL;
            default:            state_nxt = (heap == '0) ? S_RESP : S_CLEAN;
          endcase
        end
      end
      S_SCAN: begin
        if (rv_r && scan_res.hit) begin
          state_nxt = S_FILL;
        end else if (at_last) begin
          state_nxt = S_RESP;
        end
      end
      S_FILL, S_CLEAN: begin
        if (at_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    iss_nxt      = iss_r;
    dw_nxt       = dw_r;
    last_nxt     = last_r;
    rv_nxt       = 1'b0;
    run_nxt      = run_r;
    cnt_nxt      = cnt_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    fill_val_nxt = fill_val_r;
    status_nxt   = status_r;
    first_nxt    = first_r;
    ram_we       = 1'b0;
    ram_waddr    = AW'(dw_r);
    ram_wdata    = upd_word;
    ram_re       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = {LANES{PG_FREE}};
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      S_IDLE: begin
        if (start) begin
          iss_nxt    = '0;
          run_nxt    = '0;
          cnt_nxt    = in_data.page_count;
          last_nxt   = heap_last;
          status_nxt = ST_DONE;
          first_nxt  = '0;
          case (in_data.action)
            ACT_ALLOC: begin
              if (!cnt_zero && alloc_quick) begin
                status_nxt = ST_NOSPACE;
              end
            end
            ACT_DIRTY, ACT_FREE: begin
              if (run_range) begin
                status_nxt = ST_RANGE;
              end
              lo_nxt       = PAGE_W'(in_data.page_index);
              hi_nxt       = PAGE_W'(req_sum);
              iss_nxt      = WCNT_W'(in_data.page_index[IDX_W-1:LANE_W]);
              last_nxt     = req_sum_m1[SUM_W-1:LANE_W];
              fill_val_nxt = (in_data.action == ACT_DIRTY) ? PG_DIRTY : PG_FREE;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN, S_FILL, S_CLEAN: begin
        // read the next word while the previous one is processed
        ram_re  = issue;
        rv_nxt  = issue;
        dw_nxt  = iss_r;
        iss_nxt = iss_r + WCNT_W'(1);
        if (state_r == S_SCAN) begin
          if (rv_r) begin
            run_nxt = scan_res.run_out;
            if (scan_res.hit) begin
              // switch to marking the found run allocated
              first_nxt    = IDX_W'(scan_res.first);
              lo_nxt       = scan_res.first;
              hi_nxt       = found_hi;
              iss_nxt      = WCNT_W'(scan_res.first[PAGE_W-1:LANE_W]);
              last_nxt     = WCNT_W'(found_hm1[PAGE_W-1:LANE_W]);
              fill_val_nxt = PG_ALLOC;
              rv_nxt       = 1'b0;
            end else if (at_last) begin
              status_nxt = ST_NOSPACE;
              first_nxt  = '0;
            end
          end
        end else begin
          ram_we = rv_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      rv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rv_r      <= rv_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    dw_r       <= dw_nxt;
    last_r     <= last_nxt;
    run_r      <= run_nxt;
    cnt_r      <= cnt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    fill_val_r <= fill_val_nxt;
    status_r   <= status_nxt;
    first_r    <= first_nxt;
  end

  // transaction ports
  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_RESP);
  assign out_data.status     = status_r;
  assign out_data.first_page = first_r;

endmodule

`default_nettype wire

>>> rtl/core/pmf_checker.sv
// port-level checks for the page map allocator, bound to the top level
`default_nettype none

module pmf_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire pmf_pkg::pmf_out_t out_data
);
  import pmf_pkg::*;

  // an accepted transaction holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result only appears while a transaction is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // the block is free again right after its result
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("block not idle after result");

  // failed requests carry no page
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_DONE) |-> (out_data.first_page == '0))
    else $error("nonzero first page on failed request");

endmodule

bind page_map_first_fit_allocator pmf_checker u_pmf_checker (.*);

`default_nettype wire

>>> bench/page_map_checker.sv
// checker for the page allocator: watches both channels, predicts each result and compares
`timescale 1ns / 100ps

module page_map_checker #(
  parameter int MAP_PAGES = pmf_pkg::DEFAULT_MAX_PAGES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  pmf_pkg::pmf_in_t           in_data,
  input  logic                       out_valid,
  input  pmf_pkg::pmf_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [pmf_pkg::HEAP_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         outstanding
);
  import pmf_pkg::*;

  // shadow copy of the page map and the heap size register
  pg_state_t         shadow_map [MAP_PAGES];
  logic [HEAP_W-1:0] shadow_heap;
  pmf_out_t          answer_q [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // apply one request to the shadow map and work out its answer
  task automatic apply_request(input pmf_in_t req, output pmf_out_t res);
    int      h;
    int      idx;
    int      cnt;
    int      run;
    int      first;
    bit      found;
    status_t st;
    h     = (shadow_heap > MAP_PAGES) ? MAP_PAGES : int'(shadow_heap);
    idx   = int'(req.page_index);
    cnt   = int'(req.page_count);
    st    = ST_DONE;
    first = 0;
    case (action_t'(req.action))
      ACT_ALLOC: begin
        if (cnt == 0) begin
          first = 0;
        end else if (cnt > h) begin
          st = ST_NOSPACE;
        end else begin
          // first-fit search from page 0
          run   = 0;
          found = 1'b0;
          for (int p = 0; p < h && !found; p++) begin
            if (shadow_map[p] == PG_FREE) begin
              run++;
              if (run == cnt) begin
                first = p + 1 - cnt;
                found = 1'b1;
              end
            end else begin
              run = 0;
            end
          end
          if (found) begin
            for (int k = 0; k < cnt; k++) shadow_map[first + k] = PG_ALLOC;
          end else begin
            st    = ST_NOSPACE;
            first = 0;
          end
        end
      end
      ACT_DIRTY, ACT_FREE: begin
        if (idx + cnt > h) begin
          st = ST_RANGE;
        end else begin
          for (int k = 0; k < cnt; k++)
            shadow_map[idx + k] = (req.action == ACT_DIRTY) ? PG_DIRTY : PG_FREE;
        end
      end
      default: begin
        // free-dirty touches only the heap
        for (int p = 0; p < h; p++)
          if (shadow_map[p] == PG_DIRTY) shadow_map[p] = PG_FREE;
      end
    endcase
    res.status     = st;
    res.first_page = first[IDX_W-1:0];
  endtask

  task automatic report_failure(input string what, input pmf_out_t want, input pmf_out_t got);
    if (fail_count < 10)
      $display("%0t: %s: expected status %0d first_page %0d, got status %0d first_page %0d",
               $realtime, what, want.status, want.first_page, got.status, got.first_page);
    fail_count++;
  endtask

  // compare results, predict accepted transactions, track the register
  always @(posedge clk) begin
    pmf_out_t want;
    pmf_out_t got;
    if (!rst_n) begin
      foreach (shadow_map[p]) shadow_map[p] = PG_FREE;
      shadow_heap = HEAP_RESET;
      answer_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        got = out_data;
        if (answer_q.size() == 0) begin
          want = '0;
          report_failure("result with no transaction waiting", want, got);
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status || got.first_page !== want.first_page)
            report_failure("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        apply_request(in_data, want);
        answer_q.push_back(want);
      end
      if (cfg_we) shadow_heap = cfg_wdata;
    end
    outstanding <= answer_q.size();
  end

endmodule

>>> bench/tb.sv
// testbench top for the page allocator: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;
  import pmf_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pmf_in_t           in_data;
  logic              out_valid;
  pmf_out_t          out_data;
  logic              cfg_we;
  logic [HEAP_W-1:0] cfg_wdata;
  int                fail_count;
  int                outstanding;

  int                idle_pct;
  int                heap_eff;

  page_map_first_fit_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  page_map_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #10000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic pmf_in_t make_req(action_t act, int idx, int cnt);
    pmf_in_t req;
    req.action     = act;
    req.page_index = idx[IDX_W-1:0];
    req.page_count = cnt[CNT_W-1:0];
    return req;
  endfunction

  // mostly well-formed requests sized to the heap, some raw noise
  function automatic pmf_in_t random_req(int h);
    pmf_in_t req;
    int      r;
    int      cnt;
    int      idx;
    int      room;
    if ($urandom_range(99) < 12) begin
      req.action     = 2'($urandom_range(3));
      req.page_index = IDX_W'($urandom_range(1023));
      req.page_count = CNT_W'($urandom_range(2047));
      return req;
    end
    r = $urandom_range(99);
    if ($urandom_range(99) < 4) cnt = 0;
    else if ($urandom_range(99) < 10) cnt = $urandom_range(1, (h > 0) ? h : 1);
    else cnt = $urandom_range(1, 16);
    idx = (h > 0) ? $urandom_range(0, h - 1) : 0;
    room = h - idx;
    if (room > 0 && cnt > room && $urandom_range(99) < 75) cnt = $urandom_range(1, room);
    if (r < 40) req = make_req(ACT_ALLOC, $urandom_range(1023), cnt);
    else if (r < 62) req = make_req(ACT_DIRTY, idx, cnt);
    else if (r < 90) req = make_req(ACT_FREE, idx, cnt);
    else req = make_req(ACT_FREE_DIRTY, $urandom_range(1023), $urandom_range(2047));
    return req;
  endfunction

  // offer one transaction, with random idle cycles ahead of it; returns at the next negedge
  task automatic send_req(input pmf_in_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  // hold off until every expected result has come and the block is idle
  task automatic drain;
    start <= 1'b0;
    forever begin
      @(posedge clk);
      if (outstanding == 0 && !busy) break;
    end
    @(negedge clk);
  endtask

  task automatic set_heap(input int pages);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= pages[HEAP_W-1:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
    heap_eff = (pages > DEFAULT_MAX_PAGES) ? DEFAULT_MAX_PAGES : pages;
  endtask

  // stimulus
  initial begin
    int heaps [3][3];
    int pcts [3];
    heaps = '{'{1024, 64, 1}, '{2047, 200, 0}, '{1024, 17, 1000}};
    pcts  = '{35, 52, 0};
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 0;
    heap_eff  = DEFAULT_MAX_PAGES;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: full heap after reset
    set_heap(1024);
    send_req(make_req(ACT_ALLOC, 0, 0));          // zero-page allocate
    send_req(make_req(ACT_ALLOC, 1023, 1));
    send_req(make_req(ACT_ALLOC, 0, 5));
    send_req(make_req(ACT_DIRTY, 0, 3));          // overwrite allocated pages
    send_req(make_req(ACT_DIRTY, 8, 4));
    send_req(make_req(ACT_FREE_DIRTY, 0, 0));
    send_req(make_req(ACT_ALLOC, 0, 2));
    send_req(make_req(ACT_FREE, 1, 0));           // zero-page run inside heap
    send_req(make_req(ACT_FREE, 1023, 1));        // run ending at the heap end
    send_req(make_req(ACT_DIRTY, 1023, 2));       // run past heap
    send_req(make_req(ACT_ALLOC, 0, 1025));       // more pages than the heap
    send_req(make_req(ACT_ALLOC, 1023, 2047));
    send_req(make_req(ACT_DIRTY, 1023, 2047));
    send_req(make_req(ACT_DIRTY, 900, 4));
    send_req(make_req(ACT_ALLOC, 0, 1016));
    send_req(make_req(ACT_ALLOC, 0, 1));          // single page, first fit finds page 2
    // empty heap
    set_heap(0);
    send_req(make_req(ACT_ALLOC, 0, 1));
    send_req(make_req(ACT_ALLOC, 0, 0));
    send_req(make_req(ACT_FREE, 0, 0));           // zero-page run at the heap end
    send_req(make_req(ACT_FREE, 1, 0));           // zero-page run past the heap
    send_req(make_req(ACT_FREE_DIRTY, 0, 0));
    // small heap, dirty pages above it stay untouched
    set_heap(8);
    send_req(make_req(ACT_FREE_DIRTY, 0, 0));
    send_req(make_req(ACT_FREE, 0, 8));
    send_req(make_req(ACT_ALLOC, 0, 8));
    // register above the map size
    set_heap(2047);
    send_req(make_req(ACT_FREE, 0, 1024));

    // random phases, each idling mode over several heap sizes
    foreach (pcts[ph]) begin
      idle_pct = pcts[ph];
      for (int hs = 0; hs < 3; hs++) begin
        set_heap(heaps[ph][hs]);
        repeat (45) begin
          send_req(random_req(heap_eff));
          if ($urandom_range(39) == 0) drain();
        end
      end
    end

    // wind down
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
